@@ design/bf_pkg.sv @@
// Shared constants for the Bloom filter block.
package bf_pkg;

  localparam longint FILTER_BITS_DEF = 2097152;
  localparam int     HASH_COUNT_DEF  = 4;
  localparam int     WORD_BITS       = 32;
  localparam int     HASH_IN         = 8;

endpackage

@@ design/bf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bf_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // A read of an address written in the same cycle returns the old word.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ design/bloom_filter_insert_test.sv @@
// Top level of the Bloom filter insert-and-test block.
//
// Input requests arrive on the in_ channel: in_tuser is the command (insert
// and test, or clear the whole filter) and in_tdata carries eight hash words,
// of which the first HASH_COUNT are used. Every request produces exactly one
// result on the out_ channel: bit 0 of out_tdata is set when every bit named
// by the key was already set before the insert, and is zero for a clear.
// The filter word memory does one read and one write per cycle, so one hash
// word is handled per cycle. When FILTER_BITS is not a power of two, each
// hash word is first reduced modulo FILTER_BITS by a reciprocal
// multiplication and one correction step.
// A clear, and reset as well, sweeps the memory one word per cycle; no
// request is accepted meanwhile.
// The result sits in an output register, so a new request is accepted while
// a result still waits; if the receiver stalls, the block holds the next
// finished result until the register frees up.
module bloom_filter_insert_test #(
  parameter longint FILTER_BITS = bf_pkg::FILTER_BITS_DEF,
  parameter int     HASH_COUNT  = bf_pkg::HASH_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // hash_0 [31:0], hash_1 .. hash_7 above it
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // already_present [0], zero fill above
);

  localparam int WB      = bf_pkg::WORD_BITS;
  localparam int K       = (HASH_COUNT > bf_pkg::HASH_IN) ? bf_pkg::HASH_IN : HASH_COUNT;
  localparam int IW      = (K > 1) ? $clog2(K) : 1;
  localparam int HN      = 2 ** IW;
  localparam int BIT_W   = $clog2(FILTER_BITS);
  localparam int AW      = (BIT_W > 5) ? BIT_W - 5 : 1;
  localparam int WORDS   = int'((FILTER_BITS + 31) / 32);
  localparam bit IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;
  // floor(2^32 / FILTER_BITS): the quotient estimate is at most one short.
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / FILTER_BITS);
  localparam logic [31:0] FB32  = 32'(FILTER_BITS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_RMW    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_res_r, clr_res_nxt;
  logic [31:0]   h_r [HN];
  logic [IW:0]   cnt_r, cnt_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [31:0]   q_r;
  logic [31:0]   rem_r;
  logic          all_r, all_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic [AW-1:0] s1_addr_r;
  logic [4:0]    s1_bit_r;
  logic          wr_v_r, wr_v_nxt;
  logic [AW-1:0] wr_addr_r;
  logic [WB-1:0] wr_data_r;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          res_r;

  logic          accept, issue, hit, load_out;
  logic [31:0]   h_cur;
  logic [31:0]   q_est;
  logic [BIT_W-1:0] bit_sel;
  logic [AW-1:0] rd_addr;
  logic [WB-1:0] ram_rdata, cur, ram_wdata;
  logic [AW-1:0] ram_waddr;
  logic          ram_we;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, res_r};

  // The hash word that the current step works on: during reduction the one
  // being reduced, during the memory phase the one whose read is issued.
  assign h_cur   = h_r[cnt_r[IW-1:0]];
  assign q_est   = 32'((64'(h_cur) * 64'(RECIP)) >> 32);
  assign bit_sel = h_cur[BIT_W-1:0];
  assign rd_addr = AW'(bit_sel >> 5);
  assign issue   = (state_r == S_RMW) && (cnt_r != (IW + 1)'(K));

  // The word read last cycle misses a write made in that same cycle; take
  // the written word instead when the addresses match.
  assign cur = (wr_v_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : ram_rdata;
  assign hit = cur[s1_bit_r];

  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_v_r;
      ram_waddr = s1_addr_r;
      ram_wdata = cur | (WB'(1) << s1_bit_r);
    end
  end

  bf_ram #(.W(WB), .D(WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign load_out = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_res_nxt    = clr_res_r;
    cnt_nxt        = cnt_r;
    ph_nxt         = ph_r;
    all_nxt        = all_r;
    s1_v_nxt       = issue;
    wr_v_nxt       = s1_v_r && (state_r == S_RMW);
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(WORDS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_res_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          ph_nxt  = '0;
          all_nxt = 1'b1;
          if (in_tuser) begin
            clr_res_nxt = 1'b1;
            all_nxt     = 1'b0;
            state_nxt   = S_CLEAR;
          end else begin
            clr_res_nxt = 1'b0;
            state_nxt   = IS_POW2 ? S_RMW : S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        // Three steps per word: estimate the quotient, form the remainder,
        // then subtract FILTER_BITS once more if the estimate was short.
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt  = '0;
          cnt_nxt = cnt_r + (IW + 1)'(1);
          if (cnt_r == (IW + 1)'(K - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_RMW;
          end
        end
      end
      S_RMW: begin
        if (issue) cnt_nxt = cnt_r + (IW + 1)'(1);
        if (s1_v_r && !hit) all_nxt = 1'b0;
        if (s1_v_r && !issue) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      clr_res_r    <= 1'b0;
      cnt_r        <= '0;
      ph_r         <= '0;
      all_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      wr_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_res_r    <= clr_res_nxt;
      cnt_r        <= cnt_nxt;
      ph_r         <= ph_nxt;
      all_r        <= all_nxt;
      s1_v_r       <= s1_v_nxt;
      wr_v_r       <= wr_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers: hash words, reduction terms, pipeline addresses,
  // write copy, result.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < HN; j++) begin
        h_r[j] <= in_tdata[32 * j +: 32];
      end
    end else if ((state_r == S_REDUCE) && (ph_r == 2'd2)) begin
      h_r[cnt_r[IW-1:0]] <= (rem_r >= FB32) ? rem_r - FB32 : rem_r;
    end
    if (state_r == S_REDUCE) begin
      q_r   <= q_est;
      rem_r <= h_cur - (q_r * FB32);
    end
    if (issue) begin
      s1_addr_r <= rd_addr;
      s1_bit_r  <= bit_sel[4:0];
    end
    wr_addr_r <= ram_waddr;
    wr_data_r <= ram_wdata;
    if (load_out) res_r <= all_r;
  end

`ifndef NO_ASSERTIONS
  // A result only appears when a finished request is handed over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the hand-over state");

  // No request may be taken while the memory is being swept.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request accepted during clearing sweep");

  // Every write-back of an insert carries the bit it was meant to set.
  a_wb_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == S_RMW)) |-> ram_wdata[s1_bit_r])
    else $error("write-back lost the selected bit");
`endif

endmodule

@@ tb/sv/bf_tb_pkg.sv @@
// Command codes shared by the Bloom filter testbench and its checker.
package bf_tb_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_CLEAR  = 1'b1
  } bf_cmd_e;

endpackage

@@ tb/sv/bf_insert_checker.sv @@
// Checker that predicts and compares every Bloom filter result.
module bf_insert_checker #(
  parameter longint FILTER_BITS = bf_pkg::FILTER_BITS_DEF,
  parameter int     HASH_COUNT  = bf_pkg::HASH_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [7:0]   out_tdata,
  output int unsigned  outstanding,
  output int unsigned  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USED_HASHES = (HASH_COUNT > bf_pkg::HASH_IN) ? bf_pkg::HASH_IN : HASH_COUNT;

  // Shadow of the filter array; a missing entry is an all-zero word.
  bit [31:0]   filter_word [longint unsigned];
  logic [7:0]  presence_q [$];
  int unsigned result_idx = 0;
  int unsigned mismatches = 0;

  assign fail_count = mismatches;

  // Tests and sets each named bit in order, as the block does.
  function automatic logic insert_key(logic [255:0] hashes);
    logic             all_set;
    longint unsigned  bitn;
    longint unsigned  widx;
    logic [31:0]      mask;
    logic [31:0]      cur;
    all_set = 1'b1;
    for (int i = 0; i < USED_HASHES; i++) begin
      bitn = {32'b0, hashes[32*i +: 32]} % FILTER_BITS;
      widx = bitn / bf_pkg::WORD_BITS;
      mask = 32'h1 << bitn[4:0];
      cur  = filter_word.exists(widx) ? filter_word[widx] : '0;
      if ((cur & mask) == '0) begin
        all_set           = 1'b0;
        filter_word[widx] = cur | mask;
      end
    end
    return all_set;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $time, result_idx, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      // Results are taken before new requests so a result can never match
      // a request accepted at the same edge.
      if (out_tvalid && out_tready) begin
        if (presence_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%02h", out_tdata));
        end else begin
          want = presence_q.pop_front();
          if (out_tdata[0] !== want[0])
            report_mismatch($sformatf("already_present %b, expected %b",
                                      out_tdata[0], want[0]));
          if (out_tdata[7:1] !== want[7:1])
            report_mismatch($sformatf("fill bits 0x%02h, expected zero", out_tdata[7:1]));
        end
        result_idx++;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == bf_tb_pkg::CMD_CLEAR) begin
          filter_word.delete();
          presence_q.push_back(8'h00);
        end else begin
          presence_q.push_back({7'b0, insert_key(in_tdata)});
        end
      end
      outstanding <= presence_q.size();
    end
  end

endmodule

@@ tb/sv/tb_bloom_filter_insert_test.sv @@
// Top of the Bloom filter testbench: stimulus, idling, watchdog and verdict.
module tb_bloom_filter_insert_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FILTER_BITS     = bf_pkg::FILTER_BITS_DEF;
  localparam int     HASH_COUNT      = bf_pkg::HASH_COUNT_DEF;
  localparam int     USED_HASHES     = (HASH_COUNT > bf_pkg::HASH_IN) ? bf_pkg::HASH_IN : HASH_COUNT;
  localparam longint FILTER_WORDS    = (FILTER_BITS + 31) / 32;
  localparam int     RANDOM_REQUESTS = 2000;
  localparam int     MAX_CLEARS      = 4;
  localparam int     KEY_POOL_DEPTH  = 512;
  localparam int     DRAIN_CYCLES    = 4 * (HASH_COUNT + 3);
  // The longest quiet stretch in a correct run is one clear sweep, or the
  // sweep after reset, plus a stalled result. Allow several times that.
  localparam longint WATCHDOG_LIMIT  = 4 * (FILTER_WORDS + 1024);

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata   = '0;     // hash_0 [31:0], hash_1 .. hash_7 above it
  logic         in_tuser   = bf_tb_pkg::CMD_INSERT; // cmd
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;           // already_present [0], zero fill above

  int unsigned  outstanding;
  int unsigned  fail_count;
  int unsigned  send_idle_pct = 30;
  int unsigned  recv_idle_pct = 55;
  longint       quiet_cycles  = 0;

  // Keys inserted since the last clear; reusing them is what makes the
  // filter answer "already present".
  logic [255:0] key_pool [$];

  bloom_filter_insert_test #(
    .FILTER_BITS(FILTER_BITS),
    .HASH_COUNT (HASH_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bf_insert_checker #(
    .FILTER_BITS(FILTER_BITS),
    .HASH_COUNT (HASH_COUNT)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  always #10 clk = ~clk;

  // The receiver stalls at random; the percentage changes with the phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Any handshake on either channel counts as progress. A long stretch with
  // none means the block has hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly full-range words, with the two extremes mixed in now and then.
  function automatic logic [31:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    return $urandom();
  endfunction

  function automatic logic [255:0] fresh_key();
    logic [255:0] key;
    for (int i = 0; i < bf_pkg::HASH_IN; i++) key[32*i +: 32] = random_word();
    return key;
  endfunction

  // Another word that names the same bit once reduced modulo the filter size.
  function automatic logic [31:0] alias_word(logic [31:0] w);
    longint unsigned bitn;
    longint unsigned spare;
    bitn  = {32'b0, w} % FILTER_BITS;
    spare = (64'hFFFF_FFFF - bitn) / FILTER_BITS;
    return 32'(bitn + FILTER_BITS * $urandom_range(0, 32'(spare)));
  endfunction

  // The words the block ignores get fresh random content.
  function automatic logic [255:0] with_spare_words(logic [255:0] key);
    for (int i = USED_HASHES; i < bf_pkg::HASH_IN; i++) key[32*i +: 32] = $urandom();
    return key;
  endfunction

  function automatic logic [255:0] make_key(logic [31:0] w0, logic [31:0] w1,
                                            logic [31:0] w2, logic [31:0] w3);
    logic [255:0] key;
    key = fresh_key();
    key[127:0] = {w3, w2, w1, w0};
    return key;
  endfunction

  // Presents one request and returns at the edge where it is accepted.
  // The valid is only lowered when an idle gap is taken, so a back-to-back
  // request never sees valid dropped and raised in the same step.
  task automatic send_request(input bf_tb_pkg::bf_cmd_e cmd, input logic [255:0] hashes);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= hashes;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted result has come back. The
  // first edge lets the checker count the request accepted just before.
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [255:0] key;
    logic [255:0] base;
    logic [255:0] pal;
    int unsigned  pick;
    int unsigned  clears_left;

    clears_left = MAX_CLEARS;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. All-zero words name bit 0 four times over: the first
    // sight of the key must say "new" even though later words see the bit
    // that the first one just set.
    key = make_key('0, '0, '0, '0);
    send_request(bf_tb_pkg::CMD_INSERT, key);
    send_request(bf_tb_pkg::CMD_INSERT, with_spare_words(key));
    // The top bit of the array, then words that wrap around onto bit 0.
    send_request(bf_tb_pkg::CMD_INSERT, make_key('1, '1, '1, '1));
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'(FILTER_BITS), 32'(FILTER_BITS),
                                                 32'(FILTER_BITS), 32'(FILTER_BITS)));
    // Bits on either side of the word boundaries.
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'd31, 32'd32, 32'd63, 32'd64));
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'd64, 32'd63, 32'd32, 32'd31));
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'd31, '1, 32'd32, '0));
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'd31, 32'd32, '0, 32'd1));
    // Alternating bit patterns, then the same key with its spare words flipped.
    key = make_key(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000);
    send_request(bf_tb_pkg::CMD_INSERT, key);
    key[255:128] = ~key[255:128];
    send_request(bf_tb_pkg::CMD_INSERT, key);
    // A random key twice, and a key whose later words alias its first one.
    key = fresh_key();
    send_request(bf_tb_pkg::CMD_INSERT, key);
    send_request(bf_tb_pkg::CMD_INSERT, with_spare_words(key));
    key = fresh_key();
    for (int i = 1; i < USED_HASHES; i++) key[32*i +: 32] = alias_word(key[31:0]);
    send_request(bf_tb_pkg::CMD_INSERT, key);
    // A clear, after which keys seen before must read as new again.
    drain_requests();
    send_request(bf_tb_pkg::CMD_CLEAR, '1);
    send_request(bf_tb_pkg::CMD_INSERT, make_key('0, '0, '0, '0));
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'd31, 32'd32, 32'd63, 32'd64));
    send_request(bf_tb_pkg::CMD_INSERT, make_key(32'd31, 32'd32, 32'd63, 32'd64));
    send_request(bf_tb_pkg::CMD_CLEAR, '0);
    send_request(bf_tb_pkg::CMD_INSERT, make_key('1, '1, '1, '1));

    // Random part. Most keys are built from keys already inserted, so many
    // of them find all their bits set; the rest are fresh keys.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 3) begin
        drain_requests();
        send_idle_pct = 55;
        recv_idle_pct = 30;
      end else if (n == 2 * RANDOM_REQUESTS / 3) begin
        drain_requests();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(0, 999);
      if (pick < 3 && clears_left > 0) begin
        // Clears are rare since each one sweeps the whole array.
        clears_left--;
        send_request(bf_tb_pkg::CMD_CLEAR, fresh_key());
        key_pool.delete();
      end else begin
        key = fresh_key();
        if (key_pool.size() != 0) begin
          base = key_pool[$urandom_range(0, key_pool.size() - 1)];
          if (pick < 400) begin
            key = with_spare_words(base);
          end else if (pick < 550) begin
            for (int i = 0; i < USED_HASHES; i++)
              key[32*i +: 32] = alias_word(base[32*i +: 32]);
          end else if (pick < 700) begin
            // Every bit was set by some earlier key, none by this one.
            for (int i = 0; i < USED_HASHES; i++) begin
              pal = key_pool[$urandom_range(0, key_pool.size() - 1)];
              key[32*i +: 32] = pal[32*$urandom_range(0, USED_HASHES - 1) +: 32];
            end
          end else if (pick < 800) begin
            key = base;
            key[32*$urandom_range(0, USED_HASHES - 1) +: 32] = $urandom();
          end
        end
        if (pick >= 800 && pick < 900 && USED_HASHES > 1) begin
          key[32*$urandom_range(1, USED_HASHES - 1) +: 32] = alias_word(key[31:0]);
        end
        send_request(bf_tb_pkg::CMD_INSERT, key);
        key_pool.push_back(key);
        if (key_pool.size() > KEY_POOL_DEPTH) key_pool.delete($urandom_range(0, KEY_POOL_DEPTH - 1));
      end
    end

    // Wait for the last results, then a little longer for any stray ones.
    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
